### rtl/pmftl_pkg.sv
// shared types and constants of the page-mapped flash translation engine
package pmftl_pkg;

   localparam int PAGES_PER_BLOCK = 16;
   localparam int PHYS_BLOCKS     = 64;
   localparam int LOGICAL_PAGES   = 768;

   localparam int PAGE_W  = 4;
   localparam int PTR_W   = 5;
   localparam int BLOCK_W = 6;
   localparam int LPN_W   = 10;
   localparam int PHYS_W  = BLOCK_W + PAGE_W;
   localparam int MAP_W   = PHYS_W + 1;
   localparam int CNT_W   = 5;
   localparam int BLK_W   = CNT_W + PAGES_PER_BLOCK;
   localparam int BUF_W   = 8;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int SCAN_W  = BLOCK_W + 1;
   localparam int EMIT_W  = 3;

   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PROG  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ERASE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_ZERO  = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_DST_FULL = 2'd2;

   localparam logic [EMIT_W-1:0] EM_READ      = 3'd0;
   localparam logic [EMIT_W-1:0] EM_ZERO      = 3'd1;
   localparam logic [EMIT_W-1:0] EM_NO_EMPTY  = 3'd2;
   localparam logic [EMIT_W-1:0] EM_DST_FULL  = 3'd3;
   localparam logic [EMIT_W-1:0] EM_ERASE     = 3'd4;
   localparam logic [EMIT_W-1:0] EM_COPY_RD   = 3'd5;
   localparam logic [EMIT_W-1:0] EM_COPY_PG   = 3'd6;
   localparam logic [EMIT_W-1:0] EM_HOST_PG   = 3'd7;

   typedef struct packed {
      logic              take;
      logic              clr;
      logic              scan_start;
      logic              scan_step;
      logic              scan_excl;
      logic              set_dst;
      logic              set_src;
      logic              open_init;
      logic              erase_wr;
      logic              src_rd;
      logic              src_cap;
      logic              pg_inc;
      logic              own_cap;
      logic              l2p_rd;
      logic              cap_old;
      logic              rm_wr;
      logic              rm_inc;
      logic              ob_rd;
      logic              ob_wr;
      logic              own_wr;
      logic              ptr_inc;
      logic              rm_owner;
      logic              load;
      logic [EMIT_W-1:0] emit_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_write;
      logic lpn_oob;
      logic open_full;
      logic map_zero_rd;
      logic old_zero;
      logic scan_done;
      logic best_nonzero;
      logic best_full;
      logic src_empty;
      logic pg_end;
      logic pg_bit;
      logic owner_oob;
      logic out_free;
      logic clr_done;
   } dp_stat_type;

endpackage

### rtl/pmftl_ram.sv
// generic single-write, single-read memory with registered read data
module pmftl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/pmftl_dp.sv
// datapath: map, block and spare-area memories, scan, copy and result registers
module pmftl_dp
   import pmftl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_stat_type         stat,
   input  logic [23:0]         req_tdata,
   input  logic                req_tuser,
   input  logic                csr_valid,
   input  logic [BUF_W-1:0]    csr_data,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [31:0]         rsp_tdata,
   output logic [CMD_W-1:0]    rsp_tuser,
   output logic                rsp_tlast
);
   logic                 type_ff;
   logic [LPN_W-1:0]     lpn_ff;
   logic [BUF_W-1:0]     buf_ff;
   logic [BUF_W-1:0]     copy_buf_ff;
   logic [LPN_W-1:0]     clr_idx_ff;
   logic [SCAN_W-1:0]    scan_idx_ff;
   logic                 best_has_ff;
   logic [CNT_W-1:0]     best_cnt_ff;
   logic [BLOCK_W-1:0]   best_idx_ff;
   logic [BLOCK_W-1:0]   dst_ff;
   logic [BLOCK_W-1:0]   src_ff;
   logic                 src_empty_ff;
   logic [PAGES_PER_BLOCK-1:0] bits_ff;
   logic [PTR_W-1:0]     pg_ff;
   logic [LPN_W-1:0]     owner_ff;
   logic [MAP_W-1:0]     old_ff;
   logic [BLOCK_W-1:0]   open_blk_ff;
   logic [PTR_W-1:0]     open_ptr_ff;
   logic                 rsp_valid_ff;
   logic [CMD_W-1:0]     o_cmd_ff;
   logic [BLOCK_W-1:0]   o_blk_ff;
   logic [PAGE_W-1:0]    o_pg_ff;
   logic [BUF_W-1:0]     o_buf_ff;
   logic [LPN_W-1:0]     o_spare_ff;
   logic [STAT_W-1:0]    o_stat_ff;
   logic                 o_last_ff;

   logic                 l2p_we;
   logic [LPN_W-1:0]     l2p_waddr, l2p_raddr;
   logic [MAP_W-1:0]     l2p_wdata, l2p_rdata;
   logic                 blk_we;
   logic [BLOCK_W-1:0]   blk_waddr, blk_raddr;
   logic [BLK_W-1:0]     blk_wdata, blk_rdata;
   logic [PHYS_W-1:0]    own_waddr, own_raddr;
   logic [LPN_W-1:0]     own_wdata, own_rdata;

   logic [LPN_W-1:0]     rm_lpn;
   logic [MAP_W-1:0]     old_m1;
   logic [BLOCK_W-1:0]   ob;
   logic [PAGE_W-1:0]    op;
   logic [CNT_W-1:0]     rd_cnt;
   logic [PAGES_PER_BLOCK-1:0] rd_bits;
   logic [PAGES_PER_BLOCK-1:0] ptr_hot, op_hot;
   logic [BLOCK_W-1:0]   scan_prev;
   logic                 scan_cand;

   logic [CMD_W-1:0]     e_cmd;
   logic [BLOCK_W-1:0]   e_blk;
   logic [PAGE_W-1:0]    e_pg;
   logic [BUF_W-1:0]     e_buf;
   logic [LPN_W-1:0]     e_spare;
   logic [STAT_W-1:0]    e_stat;
   logic                 e_last;

   assign rm_lpn    = cmd.rm_owner ? owner_ff : lpn_ff;
   assign old_m1    = old_ff - MAP_W'(1);
   assign ob        = old_m1[PHYS_W-1:PAGE_W];
   assign op        = old_m1[PAGE_W-1:0];
   assign rd_cnt    = blk_rdata[BLK_W-1:PAGES_PER_BLOCK];
   assign rd_bits   = blk_rdata[PAGES_PER_BLOCK-1:0];
   assign ptr_hot   = PAGES_PER_BLOCK'(1) << open_ptr_ff[PAGE_W-1:0];
   assign op_hot    = PAGES_PER_BLOCK'(1) << op;
   assign scan_prev = BLOCK_W'(scan_idx_ff - SCAN_W'(1));
   assign scan_cand = (scan_idx_ff != '0) && !(cmd.scan_excl && scan_prev == dst_ff)
                      && (!best_has_ff || rd_cnt < best_cnt_ff);

   // memory port selection
   always_comb begin
      l2p_we    = 1'b0;
      l2p_waddr = rm_lpn;
      l2p_wdata = MAP_W'({open_blk_ff, open_ptr_ff[PAGE_W-1:0]}) + MAP_W'(1);
      l2p_raddr = rm_lpn;
      if (cmd.clr) begin
         l2p_we    = 1'b1;
         l2p_waddr = clr_idx_ff;
         l2p_wdata = '0;
      end else if (cmd.rm_wr) begin
         l2p_we = 1'b1;
      end

      blk_we    = 1'b0;
      blk_waddr = open_blk_ff;
      blk_wdata = '0;
      if (cmd.clr) begin
         blk_we    = (clr_idx_ff < LPN_W'(PHYS_BLOCKS));
         blk_waddr = clr_idx_ff[BLOCK_W-1:0];
      end else if (cmd.erase_wr) begin
         blk_we    = 1'b1;
         blk_waddr = dst_ff;
      end else if (cmd.rm_inc) begin
         blk_we    = 1'b1;
         blk_wdata = {rd_cnt + CNT_W'(1), rd_bits | ptr_hot};
      end else if (cmd.ob_wr) begin
         blk_we    = 1'b1;
         blk_waddr = ob;
         blk_wdata = {(rd_cnt != '0) ? rd_cnt - CNT_W'(1) : rd_cnt, rd_bits & ~op_hot};
      end

      priority if (cmd.scan_step) blk_raddr = scan_idx_ff[BLOCK_W-1:0];
      else if (cmd.src_rd)        blk_raddr = src_ff;
      else if (cmd.ob_rd)         blk_raddr = ob;
      else                        blk_raddr = open_blk_ff;

      own_raddr = {src_ff, pg_ff[PAGE_W-1:0]};
      own_waddr = {open_blk_ff, open_ptr_ff[PAGE_W-1:0]};
      own_wdata = rm_lpn;
   end

   pmftl_ram #(.WIDTH(MAP_W), .DEPTH(LOGICAL_PAGES)) u_l2p (
      .clock(clock), .we(l2p_we), .waddr(l2p_waddr), .wdata(l2p_wdata),
      .raddr(l2p_raddr), .rdata(l2p_rdata)
   );

   pmftl_ram #(.WIDTH(BLK_W), .DEPTH(PHYS_BLOCKS)) u_blk (
      .clock(clock), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
      .raddr(blk_raddr), .rdata(blk_rdata)
   );

   pmftl_ram #(.WIDTH(LPN_W), .DEPTH(PHYS_BLOCKS * PAGES_PER_BLOCK)) u_own (
      .clock(clock), .we(cmd.own_wr), .waddr(own_waddr), .wdata(own_wdata),
      .raddr(own_raddr), .rdata(own_rdata)
   );

   // result field selection
   always_comb begin
      e_cmd   = CMD_READ;
      e_blk   = '0;
      e_pg    = '0;
      e_buf   = '0;
      e_spare = '0;
      e_stat  = STAT_OK;
      e_last  = 1'b0;
      unique case (cmd.emit_sel)
         EM_READ: begin
            e_blk  = ob;
            e_pg   = op;
            e_buf  = buf_ff;
            e_last = 1'b1;
         end
         EM_ZERO: begin
            e_cmd  = CMD_ZERO;
            e_buf  = buf_ff;
            e_last = 1'b1;
         end
         EM_NO_EMPTY: begin
            e_stat = STAT_NO_EMPTY;
            e_last = 1'b1;
         end
         EM_DST_FULL: begin
            e_stat = STAT_DST_FULL;
            e_last = 1'b1;
         end
         EM_ERASE: begin
            e_cmd = CMD_ERASE;
            e_blk = dst_ff;
         end
         EM_COPY_RD: begin
            e_blk = src_ff;
            e_pg  = pg_ff[PAGE_W-1:0];
            e_buf = copy_buf_ff;
         end
         EM_COPY_PG: begin
            e_cmd   = CMD_PROG;
            e_blk   = open_blk_ff;
            e_pg    = open_ptr_ff[PAGE_W-1:0];
            e_buf   = copy_buf_ff;
            e_spare = owner_ff;
         end
         EM_HOST_PG: begin
            e_cmd   = CMD_PROG;
            e_blk   = open_blk_ff;
            e_pg    = open_ptr_ff[PAGE_W-1:0];
            e_buf   = buf_ff;
            e_spare = lpn_ff;
            e_last  = 1'b1;
         end
         default: begin
            e_cmd = CMD_READ;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         copy_buf_ff  <= '0;
         clr_idx_ff   <= '0;
         open_blk_ff  <= '0;
         open_ptr_ff  <= PTR_W'(PAGES_PER_BLOCK);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            copy_buf_ff <= csr_data;
         end
         if (cmd.clr) begin
            clr_idx_ff <= clr_idx_ff + LPN_W'(1);
         end
         if (cmd.open_init) begin
            open_blk_ff <= dst_ff;
            open_ptr_ff <= '0;
         end else if (cmd.ptr_inc) begin
            open_ptr_ff <= open_ptr_ff + PTR_W'(1);
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         type_ff <= req_tuser;
         lpn_ff  <= req_tdata[LPN_W-1:0];
         buf_ff  <= req_tdata[LPN_W+BUF_W-1:LPN_W];
      end
      if (cmd.scan_start) begin
         scan_idx_ff <= '0;
         best_has_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + SCAN_W'(1);
         if (scan_cand) begin
            best_has_ff <= 1'b1;
            best_cnt_ff <= rd_cnt;
            best_idx_ff <= scan_prev;
         end
      end
      if (cmd.set_dst) begin
         dst_ff <= best_idx_ff;
      end
      if (cmd.set_src) begin
         src_ff       <= best_idx_ff;
         src_empty_ff <= (best_cnt_ff == '0);
      end
      if (cmd.src_cap) begin
         bits_ff <= rd_bits;
         pg_ff   <= '0;
      end else if (cmd.pg_inc) begin
         pg_ff <= pg_ff + PTR_W'(1);
      end
      if (cmd.own_cap) begin
         owner_ff <= own_rdata;
      end
      if (cmd.cap_old) begin
         old_ff <= l2p_rdata;
      end
      if (cmd.load) begin
         o_cmd_ff   <= e_cmd;
         o_blk_ff   <= e_blk;
         o_pg_ff    <= e_pg;
         o_buf_ff   <= e_buf;
         o_spare_ff <= e_spare;
         o_stat_ff  <= e_stat;
         o_last_ff  <= e_last;
      end
   end

   assign stat.is_write     = type_ff;
   assign stat.lpn_oob      = (lpn_ff >= LPN_W'(LOGICAL_PAGES));
   assign stat.open_full    = (open_ptr_ff >= PTR_W'(PAGES_PER_BLOCK));
   assign stat.map_zero_rd  = (l2p_rdata == '0);
   assign stat.old_zero     = (old_ff == '0);
   assign stat.scan_done    = (scan_idx_ff == SCAN_W'(PHYS_BLOCKS));
   assign stat.best_nonzero = (best_cnt_ff != '0);
   assign stat.best_full    = (best_cnt_ff >= CNT_W'(PAGES_PER_BLOCK));
   assign stat.src_empty    = src_empty_ff;
   assign stat.pg_end       = (pg_ff >= PTR_W'(PAGES_PER_BLOCK));
   assign stat.pg_bit       = bits_ff[pg_ff[PAGE_W-1:0]];
   assign stat.owner_oob    = (owner_ff >= LPN_W'(LOGICAL_PAGES));
   assign stat.out_free     = !rsp_valid_ff || rsp_tready;
   assign stat.clr_done     = (clr_idx_ff == LPN_W'(LOGICAL_PAGES - 1));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = o_cmd_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {2'b00, o_stat_ff, o_spare_ff, o_buf_ff, o_pg_ff, o_blk_ff};
endmodule

### rtl/pmftl_ctrl.sv
// controller state machine: request dispatch, collection and remap sequencing
module pmftl_ctrl
   import pmftl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);
   localparam logic [4:0] S_CLR     = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_DISP    = 5'd2;
   localparam logic [4:0] S_RD_REQ  = 5'd3;
   localparam logic [4:0] S_RD_CAP  = 5'd4;
   localparam logic [4:0] S_RD_EMIT = 5'd5;
   localparam logic [4:0] S_ZERO    = 5'd6;
   localparam logic [4:0] S_SCAN1   = 5'd7;
   localparam logic [4:0] S_CHK1    = 5'd8;
   localparam logic [4:0] S_SCAN2   = 5'd9;
   localparam logic [4:0] S_CHK2    = 5'd10;
   localparam logic [4:0] S_ST1     = 5'd11;
   localparam logic [4:0] S_ST2     = 5'd12;
   localparam logic [4:0] S_ERASE   = 5'd13;
   localparam logic [4:0] S_SRC_RD  = 5'd14;
   localparam logic [4:0] S_SRC_CAP = 5'd15;
   localparam logic [4:0] S_PG      = 5'd16;
   localparam logic [4:0] S_OWN_CAP = 5'd17;
   localparam logic [4:0] S_CRD     = 5'd18;
   localparam logic [4:0] S_CPG     = 5'd19;
   localparam logic [4:0] S_RM1     = 5'd20;
   localparam logic [4:0] S_RM2     = 5'd21;
   localparam logic [4:0] S_RM3     = 5'd22;
   localparam logic [4:0] S_RM4     = 5'd23;
   localparam logic [4:0] S_RM5     = 5'd24;
   localparam logic [4:0] S_CP_NEXT = 5'd25;
   localparam logic [4:0] S_WPG     = 5'd26;
   localparam logic [4:0] S_WR_DONE = 5'd27;

   logic [4:0] state_ff, state_in;
   logic       rm_gc_ff, rm_gc_in;
   logic [4:0] rm_ret;

   assign rm_ret     = rm_gc_ff ? S_CP_NEXT : S_WR_DONE;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      rm_gc_in = rm_gc_ff;
      cmd      = '0;
      cmd.rm_owner = rm_gc_ff;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            cmd.rm_owner = 1'b0;
            if (!stat.is_write) begin
               state_in = stat.lpn_oob ? S_ZERO : S_RD_REQ;
            end else if (stat.lpn_oob) begin
               state_in = S_IDLE;
            end else if (stat.open_full) begin
               cmd.scan_start = 1'b1;
               state_in = S_SCAN1;
            end else begin
               state_in = S_WPG;
            end
         end
         S_RD_REQ: begin
            cmd.rm_owner = 1'b0;
            cmd.l2p_rd   = 1'b1;
            state_in     = S_RD_CAP;
         end
         S_RD_CAP: begin
            cmd.cap_old = 1'b1;
            state_in    = stat.map_zero_rd ? S_ZERO : S_RD_EMIT;
         end
         S_RD_EMIT: begin
            cmd.emit_sel = EM_READ;
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ZERO: begin
            cmd.emit_sel = EM_ZERO;
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN1: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) state_in = S_CHK1;
         end
         S_CHK1: begin
            if (stat.best_nonzero) begin
               state_in = S_ST1;
            end else begin
               cmd.set_dst    = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN2;
            end
         end
         S_SCAN2: begin
            cmd.scan_step = 1'b1;
            cmd.scan_excl = 1'b1;
            if (stat.scan_done) state_in = S_CHK2;
         end
         S_CHK2: begin
            if (stat.best_full) begin
               state_in = S_ST2;
            end else begin
               cmd.set_src = 1'b1;
               state_in    = S_ERASE;
            end
         end
         S_ST1: begin
            cmd.emit_sel = EM_NO_EMPTY;
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ST2: begin
            cmd.emit_sel = EM_DST_FULL;
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ERASE: begin
            cmd.emit_sel = EM_ERASE;
            if (stat.out_free) begin
               cmd.load      = 1'b1;
               cmd.open_init = 1'b1;
               cmd.erase_wr  = 1'b1;
               state_in      = stat.src_empty ? S_WPG : S_SRC_RD;
            end
         end
         S_SRC_RD: begin
            cmd.src_rd = 1'b1;
            state_in   = S_SRC_CAP;
         end
         S_SRC_CAP: begin
            cmd.src_cap = 1'b1;
            state_in    = S_PG;
         end
         S_PG: begin
            if (stat.pg_end) begin
               state_in = S_WPG;
            end else if (stat.pg_bit) begin
               state_in = S_OWN_CAP;
            end else begin
               cmd.pg_inc = 1'b1;
            end
         end
         S_OWN_CAP: begin
            cmd.own_cap = 1'b1;
            state_in    = S_CRD;
         end
         S_CRD: begin
            cmd.emit_sel = EM_COPY_RD;
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_CPG;
            end
         end
         S_CPG: begin
            cmd.emit_sel = EM_COPY_PG;
            cmd.rm_owner = 1'b1;
            if (stat.out_free) begin
               cmd.load   = 1'b1;
               cmd.own_wr = 1'b1;
               rm_gc_in   = 1'b1;
               state_in   = stat.owner_oob ? S_CP_NEXT : S_RM1;
            end
         end
         S_RM1: begin
            cmd.l2p_rd = 1'b1;
            state_in   = S_RM2;
         end
         S_RM2: begin
            cmd.cap_old = 1'b1;
            cmd.rm_wr   = 1'b1;
            state_in    = S_RM3;
         end
         S_RM3: begin
            cmd.rm_inc = 1'b1;
            state_in   = stat.old_zero ? rm_ret : S_RM4;
         end
         S_RM4: begin
            cmd.ob_rd = 1'b1;
            state_in  = S_RM5;
         end
         S_RM5: begin
            cmd.ob_wr = 1'b1;
            state_in  = rm_ret;
         end
         S_CP_NEXT: begin
            cmd.ptr_inc = 1'b1;
            cmd.pg_inc  = 1'b1;
            state_in    = S_PG;
         end
         S_WPG: begin
            cmd.emit_sel = EM_HOST_PG;
            cmd.rm_owner = 1'b0;
            if (stat.out_free) begin
               cmd.load   = 1'b1;
               cmd.own_wr = 1'b1;
               rm_gc_in   = 1'b0;
               state_in   = S_RM1;
            end
         end
         S_WR_DONE: begin
            cmd.ptr_inc = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         rm_gc_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rm_gc_ff <= rm_gc_in;
      end
   end
endmodule

### rtl/page_map_ftl_with_gc.sv
// top level of the page-mapped flash translation engine with greedy collection
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser req_type; tdata lpn, buffer_id
//  rsp      out  rsp_tvalid/rsp_tready  tuser cmd; tdata block..status; tlast last
//  csr      in   csr_valid/csr_ready    copy_buffer_id
//
// a write that replaces a mapped page also invalidates the old copy in its block
// a write that collects adds two block-count scans and a setup sequence,
// plus a visit to each source page slot and a copy of each valid page
// after reset a clearing pass zeroes the map memory; no word is taken meanwhile
// a stalled result holds the engine at its next result
module page_map_ftl_with_gc
   import pmftl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // lpn, buffer_id
   input  logic              req_tuser,   // req_type
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // block, page, buf_sel, spare_lpn, status
   output logic [CMD_W-1:0]  rsp_tuser,   // cmd
   output logic              rsp_tlast,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [BUF_W-1:0]  csr_data
);
   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   assign csr_ready = 1'b1;

   pmftl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .stat(stat), .cmd(cmd)
   );

   pmftl_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .csr_valid(csr_valid), .csr_data(csr_data),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );
endmodule

### dv/page_map_ftl_with_gc_checker.sv
// checker for the flash translation engine: predicts flash command words and compares them
module page_map_ftl_with_gc_checker
   import pmftl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [23:0]       req_tdata,   // lpn, buffer_id
   input  logic              req_tuser,   // req_type
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [31:0]       rsp_tdata,   // block, page, buf_sel, spare_lpn, status
   input  logic [CMD_W-1:0]  rsp_tuser,   // cmd
   input  logic              rsp_tlast,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [BUF_W-1:0]  csr_data,
   output int                errors,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic REQ_READ = 1'b0;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [BLOCK_W-1:0] blk;
      logic [PAGE_W-1:0]  pg;
      logic [BUF_W-1:0]   bsel;
      logic [LPN_W-1:0]   spare;
      logic [STAT_W-1:0]  stat;
      logic               lst;
   } flash_cmd_type;

   flash_cmd_type    expected_cmds[$];
   logic [MAP_W-1:0] l2p[LOGICAL_PAGES];
   int               vcnt[PHYS_BLOCKS];
   logic [15:0]      vbits[PHYS_BLOCKS];
   logic [LPN_W-1:0] owner[PHYS_BLOCKS*PAGES_PER_BLOCK];
   int               open_blk;
   int               wptr;
   logic [BUF_W-1:0] copy_buf;

   task automatic report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic push_cmd(logic [CMD_W-1:0] cmd, int blk, int pg, int bsel, int spare,
                           logic [STAT_W-1:0] stat, logic lst);
      flash_cmd_type c;
      c.cmd = cmd;
      c.blk = blk[BLOCK_W-1:0];
      c.pg = pg[PAGE_W-1:0];
      c.bsel = bsel[BUF_W-1:0];
      c.spare = spare[LPN_W-1:0];
      c.stat = stat;
      c.lst = lst;
      expected_cmds.push_back(c);
   endtask

   function automatic int fewest_valid(int skip, output int cnt);
      int best;
      best = 0;
      cnt = 1 << 30;
      for (int b = 0; b < PHYS_BLOCKS; b++) begin
         if (b != skip && vcnt[b] < cnt) begin
            best = b;
            cnt = vcnt[b];
         end
      end
      return best;
   endfunction

   task automatic remap(int lpn, int blk, int pg);
      int prev;
      int ob;
      int op;
      prev = l2p[lpn];
      l2p[lpn] = blk * PAGES_PER_BLOCK + pg + 1;
      vbits[blk][pg] = 1'b1;
      vcnt[blk]++;
      if (prev != 0) begin
         ob = (prev - 1) / PAGES_PER_BLOCK;
         op = (prev - 1) % PAGES_PER_BLOCK;
         vbits[ob][op] = 1'b0;
         if (vcnt[ob] > 0) vcnt[ob]--;
      end
   endtask

   task automatic predict_commands(logic kind, int lpn, int hbuf);
      int m;
      int dcnt;
      int scnt;
      int dst;
      int src;
      int ptr;
      int own;
      if (kind == REQ_READ) begin
         m = (lpn < LOGICAL_PAGES) ? l2p[lpn] : 0;
         if (m != 0)
            push_cmd(CMD_READ, (m - 1) / PAGES_PER_BLOCK, (m - 1) % PAGES_PER_BLOCK,
                     hbuf, 0, STAT_OK, 1'b1);
         else
            push_cmd(CMD_ZERO, 0, 0, hbuf, 0, STAT_OK, 1'b1);
         return;
      end
      if (lpn >= LOGICAL_PAGES) return;
      if (wptr >= PAGES_PER_BLOCK) begin
         ptr = 0;
         dst = fewest_valid(-1, dcnt);
         if (dcnt != 0) begin
            push_cmd(CMD_READ, 0, 0, 0, 0, STAT_NO_EMPTY, 1'b1);
            return;
         end
         src = fewest_valid(dst, scnt);
         if (scnt >= PAGES_PER_BLOCK) begin
            push_cmd(CMD_READ, 0, 0, 0, 0, STAT_DST_FULL, 1'b1);
            return;
         end
         push_cmd(CMD_ERASE, dst, 0, 0, 0, STAT_OK, 1'b0);
         vbits[dst] = '0;
         if (scnt != 0) begin
            for (int pg = 0; pg < PAGES_PER_BLOCK; pg++) begin
               if (vbits[src][pg]) begin
                  own = owner[src * PAGES_PER_BLOCK + pg];
                  push_cmd(CMD_READ, src, pg, copy_buf, 0, STAT_OK, 1'b0);
                  push_cmd(CMD_PROG, dst, ptr, copy_buf, own, STAT_OK, 1'b0);
                  owner[dst * PAGES_PER_BLOCK + ptr] = own;
                  if (own < LOGICAL_PAGES) remap(own, dst, ptr);
                  ptr++;
               end
            end
         end
         open_blk = dst;
         wptr = ptr;
      end
      push_cmd(CMD_PROG, open_blk, wptr, hbuf, lpn, STAT_OK, 1'b1);
      owner[open_blk * PAGES_PER_BLOCK + wptr] = lpn;
      remap(lpn, open_blk, wptr);
      wptr++;
   endtask

   always @(posedge clock) begin
      flash_cmd_type want;
      if (reset) begin
         expected_cmds.delete();
         for (int i = 0; i < LOGICAL_PAGES; i++) l2p[i] = '0;
         for (int b = 0; b < PHYS_BLOCKS; b++) begin
            vcnt[b] = 0;
            vbits[b] = '0;
         end
         for (int i = 0; i < PHYS_BLOCKS * PAGES_PER_BLOCK; i++) owner[i] = '0;
         open_blk = 0;
         wptr = PAGES_PER_BLOCK;
         copy_buf = '0;
         errors = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cmds.size() == 0) begin
               report($sformatf("unexpected word tdata %h tuser %0d", rsp_tdata, rsp_tuser));
            end else begin
               want = expected_cmds.pop_front();
               check_field("cmd", rsp_tuser, want.cmd);
               check_field("block", rsp_tdata[5:0], want.blk);
               check_field("page", rsp_tdata[9:6], want.pg);
               check_field("buf_sel", rsp_tdata[17:10], want.bsel);
               check_field("spare_lpn", rsp_tdata[27:18], want.spare);
               check_field("status", rsp_tdata[29:28], want.stat);
               check_field("last", rsp_tlast, want.lst);
            end
         end
         if (csr_valid && csr_ready) copy_buf = csr_data;
         if (req_tvalid && req_tready)
            predict_commands(req_tuser, req_tdata[9:0], req_tdata[17:10]);
      end
      pending = expected_cmds.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end
endmodule

### dv/tb_page_map_ftl_with_gc.sv
// testbench top for the flash translation engine: stimulus, idling phases and verdict
module tb_page_map_ftl_with_gc;
   import pmftl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [23:0]      req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [31:0]      rsp_tdata;
   logic [CMD_W-1:0] rsp_tuser;
   logic             rsp_tlast;
   logic             csr_valid;
   logic             csr_ready;
   logic [BUF_W-1:0] csr_data;
   int               errors;
   int               pending;
   int               idle_pct;
   int               stall_pct;

   page_map_ftl_with_gc DUT (.*);

   page_map_ftl_with_gc_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   task automatic send_request(logic kind, int lpn, int hbuf);
      logic hit;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'd0, hbuf[7:0], lpn[9:0]};
      do begin
         @(negedge clock);
         hit = req_tready;
         @(posedge clock);
      end while (!hit);
   endtask

   task automatic write_copy_buffer(int value);
      logic hit;
      req_tvalid <= 1'b0;
      csr_valid <= 1'b1;
      csr_data <= value[7:0];
      do begin
         @(negedge clock);
         hit = csr_ready;
         @(posedge clock);
      end while (!hit);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_request();
      int r;
      r = $urandom_range(99);
      if (r < 78)      send_request(REQ_WRITE, $urandom_range(767), $urandom_range(255));
      else if (r < 90) send_request(REQ_READ, $urandom_range(767), $urandom_range(255));
      else if (r < 95) send_request(REQ_READ, $urandom_range(1023), $urandom_range(255));
      else             send_request(REQ_WRITE, $urandom_range(1023), $urandom_range(255));
   endtask

   initial begin
      int copy_vals[4];
      int idle_vals[4];
      int stall_vals[4];
      copy_vals = '{255, 0, 170, 85};
      idle_vals = '{0, 82, 0, 9};
      stall_vals = '{0, 0, 82, 9};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_READ;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      idle_pct = 0;
      stall_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_copy_buffer(0);
      // unmapped and out-of-range reads, first write forces collection
      send_request(REQ_READ, 0, 0);
      send_request(REQ_READ, 1023, 255);
      send_request(REQ_WRITE, 0, 255);
      send_request(REQ_WRITE, 767, 0);
      send_request(REQ_WRITE, 1023, 170);
      send_request(REQ_WRITE, 768, 85);
      send_request(REQ_READ, 0, 1);
      send_request(REQ_READ, 767, 254);
      send_request(REQ_WRITE, 0, 128);
      send_request(REQ_READ, 0, 127);
      for (int i = 0; i < 14; i++) send_request(REQ_WRITE, 512 + i, i * 17);
      send_request(REQ_READ, 513, 255);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_copy_buffer(copy_vals[ph]);
         idle_pct = idle_vals[ph];
         stall_pct = stall_vals[ph];
         for (int i = 0; i < 66; i++) begin
            random_request();
            if (i == 33 && ph == 1) drain();
         end
         drain();
      end
      write_copy_buffer($urandom_range(255));
      stall_pct = 0;
      for (int i = 0; i < 20; i++) random_request();
      drain();
      repeat (200) @(posedge clock);

      if (errors == 0)
         $display("tb_page_map_ftl_with_gc: clean");
      else
         $display("tb_page_map_ftl_with_gc: errors");
      $finish;
   end

   initial begin
      #8ms;
      $display("tb_page_map_ftl_with_gc: errors");
      $finish;
   end
endmodule
